### src/oale_pkg.sv
// Shared types and constants for the ordered list engine.
`default_nettype none

package oale_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 8;
  localparam int CNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // match bits are scanned SCAN_G per cycle; SCAN_GB is its log2
  localparam int SCAN_GB = 4;
  localparam int SCAN_G  = 1 << SCAN_GB;

  typedef enum logic {
    SCAN_IDLE,
    SCAN_RUN
  } scan_state_t;

  typedef struct packed {
    logic ins;
    logic ers;
  } cell_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

`default_nettype wire

### src/oale_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares for find.
`default_nettype none

module oale_cell #(
  parameter int IXW = 9
) (
  input  wire logic                              clk,
  input  wire oale_pkg::cell_ctl_t               ctl,
  input  wire logic [IXW-1:0]                    cell_idx,
  input  wire logic [IXW-1:0]                    pos,
  input  wire logic [IXW-1:0]                    cnt,
  input  wire logic signed [oale_pkg::VAL_W-1:0] load_val,
  input  wire logic signed [oale_pkg::VAL_W-1:0] left_val,
  input  wire logic signed [oale_pkg::VAL_W-1:0] right_val,
  output logic signed [oale_pkg::VAL_W-1:0]      val_r,
  output logic                                   match
);

  logic signed [oale_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (cell_idx == pos) begin
        val_nxt = load_val;
      end else if (cell_idx > pos) begin
        val_nxt = left_val;
      end
    end else if (ctl.ers) begin
      if (cell_idx >= pos) begin
        val_nxt = right_val;
      end
    end
  end

  assign match = (val_r == load_val) && (cell_idx < cnt);

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

### src/oale_scan.sv
// Lowest-match search: shifts the match vector down one group per cycle.
`default_nettype none

module oale_scan #(
  parameter int DEPTH = 256,
  localparam int NGRP = (DEPTH + oale_pkg::SCAN_G - 1) / oale_pkg::SCAN_G,
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1,
  localparam int FW   = GW + oale_pkg::SCAN_GB
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [DEPTH-1:0] match,
  output logic                  busy,
  output oale_pkg::scan_res_t   res,
  output logic [FW-1:0]         idx
);

  localparam int VW = NGRP * oale_pkg::SCAN_G;

  oale_pkg::scan_state_t             state_r, state_nxt;
  logic [VW-1:0]                     vec_r, vec_nxt;
  logic [GW-1:0]                     grp_r, grp_nxt;
  logic [VW-1:0]                     load_vec;
  logic [oale_pkg::SCAN_G-1:0]       low;
  logic [oale_pkg::SCAN_GB-1:0]      enc;
  logic                              any_hit;

  always_comb begin
    low     = vec_r[oale_pkg::SCAN_G-1:0];
    any_hit = |low;
    enc     = '0;
    for (int j = oale_pkg::SCAN_G - 1; j >= 0; j--) begin
      if (low[j]) begin
        enc = oale_pkg::SCAN_GB'(j);
      end
    end
  end

  always_comb begin
    load_vec              = '0;
    load_vec[DEPTH-1:0]   = match;
  end

  always_comb begin
    state_nxt = state_r;
    vec_nxt   = vec_r;
    grp_nxt   = grp_r;
    res       = '0;
    unique case (state_r)
      oale_pkg::SCAN_IDLE: begin
        if (load) begin
          vec_nxt   = load_vec;
          grp_nxt   = '0;
          state_nxt = oale_pkg::SCAN_RUN;
        end
      end
      oale_pkg::SCAN_RUN: begin
        if (any_hit || (grp_r == GW'(NGRP - 1))) begin
          res.done  = 1'b1;
          res.hit   = any_hit;
          state_nxt = oale_pkg::SCAN_IDLE;
        end else begin
          vec_nxt = vec_r >> oale_pkg::SCAN_G;
          grp_nxt = GW'(grp_r + 1'b1);
        end
      end
      default: state_nxt = oale_pkg::SCAN_IDLE;
    endcase
  end

  assign busy = (state_r == oale_pkg::SCAN_RUN);
  assign idx  = {grp_r, enc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oale_pkg::SCAN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    grp_r <= grp_nxt;
  end

endmodule

`default_nettype wire

### src/ordered_array_list_engine_unit.sv
// Insert, erase and find on an ordered list held in a row of shifting cells.
// Insert, erase and bad commands: result strobe the cycle after start; busy stays low.
// Find: busy while the match scan walks 16-bit groups;
// the result strobe comes the cycle after the group holding the first match (or the last).
// Reset clears the count and the scan state; entries are left as they are.
// Results cannot be stalled: each strobe is one cycle wide.
`default_nettype none

module ordered_array_list_engine_unit #(
  parameter int DEPTH = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [oale_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [oale_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [oale_pkg::VAL_W-1:0]  in_value,
  output logic                                    out_valid,
  output logic [oale_pkg::STAT_W-1:0]             out_status,
  output logic [oale_pkg::FIDX_W-1:0]             out_found_index,
  output logic [oale_pkg::CNT_W-1:0]              out_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IXW  = (CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W;
  localparam int NGRP = (DEPTH + oale_pkg::SCAN_G - 1) / oale_pkg::SCAN_G;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int FW   = GW + oale_pkg::SCAN_GB;
  localparam int OCW  = oale_pkg::CNT_W;
  localparam int OFW  = oale_pkg::FIDX_W;

  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [oale_pkg::STAT_W-1:0]         out_status_r, status_nxt;
  logic [oale_pkg::FIDX_W-1:0]         out_found_index_r, fidx_nxt;
  logic [oale_pkg::CNT_W-1:0]          out_count_r;
  logic                                accept;
  logic                                scan_load;
  logic [IXW-1:0]                      pos_x, cnt_x, depth_x;
  oale_pkg::cell_ctl_t                 ctl;
  oale_pkg::scan_res_t                 scan_res;
  logic [FW-1:0]                       scan_idx;
  logic [DEPTH-1:0]                    match;
  logic signed [oale_pkg::VAL_W-1:0]   cell_val [DEPTH];
  logic signed [oale_pkg::VAL_W-1:0]   left_v   [DEPTH];
  logic signed [oale_pkg::VAL_W-1:0]   right_v  [DEPTH];

  assign accept  = start && !busy;
  assign pos_x   = IXW'(in_position);
  assign cnt_x   = IXW'(cnt_r);
  assign depth_x = IXW'(DEPTH);

  always_comb begin
    ctl           = '0;
    scan_load     = 1'b0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = oale_pkg::ST_BADPOS;
    fidx_nxt      = '0;
    if (accept) begin
      unique case (in_kind)
        oale_pkg::KIND_INSERT: begin
          out_valid_nxt = 1'b1;
          if (pos_x > cnt_x) begin
            status_nxt = oale_pkg::ST_BADPOS;
          end else if (cnt_x == depth_x) begin
            status_nxt = oale_pkg::ST_FULL;
          end else begin
            status_nxt = oale_pkg::ST_OK;
            ctl.ins    = 1'b1;
            cnt_nxt    = CW'(cnt_r + 1'b1);
          end
        end
        oale_pkg::KIND_ERASE: begin
          out_valid_nxt = 1'b1;
          if (pos_x >= cnt_x) begin
            status_nxt = oale_pkg::ST_BADPOS;
          end else begin
            status_nxt = oale_pkg::ST_OK;
            ctl.ers    = 1'b1;
            cnt_nxt    = CW'(cnt_r - 1'b1);
          end
        end
        oale_pkg::KIND_FIND: begin
          scan_load = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b1;
          status_nxt    = oale_pkg::ST_BADPOS;
        end
      endcase
    end
    if (scan_res.done) begin
      out_valid_nxt = 1'b1;
      status_nxt    = scan_res.hit ? oale_pkg::ST_OK : oale_pkg::ST_NOTFOUND;
      fidx_nxt      = scan_res.hit ? OFW'(scan_idx) : '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign left_v[i] = in_value;
    end else begin : g_left_mid
      assign left_v[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_right_end
      assign right_v[i] = cell_val[i];
    end else begin : g_right_mid
      assign right_v[i] = cell_val[i+1];
    end

    oale_cell #(
      .IXW (IXW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_idx  (IXW'(i)),
      .pos       (pos_x),
      .cnt       (cnt_x),
      .load_val  (in_value),
      .left_val  (left_v[i]),
      .right_val (right_v[i]),
      .val_r     (cell_val[i]),
      .match     (match[i])
    );
  end

  oale_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (scan_load),
    .match (match),
    .busy  (busy),
    .res   (scan_res),
    .idx   (scan_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_status_r      <= status_nxt;
      out_found_index_r <= fidx_nxt;
      out_count_r       <= OCW'(cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_index_r;
  assign out_count       = out_count_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= depth_x)
    else $error("entry count above capacity");

  a_direct_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind != oale_pkg::KIND_FIND)) |=> out_valid)
    else $error("missing result beat for insert/erase");

  a_fail_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != oale_pkg::ST_OK)) |-> (out_found_index == '0))
    else $error("nonzero index on failed operation");

  a_cnt_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> $past(accept))
    else $error("count changed without an accepted command");

  a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
    scan_load |=> busy)
    else $error("find accepted but scan not running");
`endif

endmodule

`default_nettype wire
